FILE: hdl/bpxr_pkg.sv
// ----------------------------------------------------------------------------
// bpxr_pkg
// Shared constants and controller/datapath interface types for the
// packet XOR responder.
// ----------------------------------------------------------------------------
package bpxr_pkg;

   localparam int BYTE_W      = 8;
   localparam int MAX_PAYLOAD = 32;
   localparam int IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int PTR_W       = $clog2(MAX_PAYLOAD + 1);

   localparam logic [BYTE_W-1:0] CMD_ENC   = 8'h01;
   localparam logic [BYTE_W-1:0] CMD_DEC   = 8'h02;
   localparam logic [BYTE_W-1:0] CMD_ERR   = 8'hFF;
   localparam logic [BYTE_W-1:0] KEY_RESET = 8'hAA;

   // source of the byte loaded into the response register
   typedef enum logic [2:0] {
      BEAT_ERR_MARK,
      BEAT_ZERO,
      BEAT_CMD,
      BEAT_SIZE,
      BEAT_DATA,
      BEAT_BCC
   } beat_sel_type;

   typedef struct packed {
      logic         take_cmd;
      logic         take_size;
      logic         take_data;
      logic         start_resp;
      logic         emit;
      beat_sel_type sel;
      logic         last;
      logic         err;
   } dp_cmd_type;

   typedef struct packed {
      logic size_zero;
      logic data_done;
      logic pkt_ok;
      logic data_more;
      logic out_free;
   } dp_status_type;

endpackage

FILE: hdl/bpxr_ctrl.sv
// ----------------------------------------------------------------------------
// bpxr_ctrl
// Packet framing and response sequencing state machine.
// ----------------------------------------------------------------------------
module bpxr_ctrl import bpxr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_CMD,
      ST_SIZE,
      ST_DATA,
      ST_BCC,
      ST_ERR0,
      ST_ERR1,
      ST_ERR2,
      ST_RCMD,
      ST_RSIZE,
      ST_RDATA
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff inside {ST_CMD, ST_SIZE, ST_DATA, ST_BCC});
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.sel  = BEAT_ZERO;
      case (state_ff)
         ST_CMD: begin
            if (accept) begin
               cmd.take_cmd = 1'b1;
               state_in     = ST_SIZE;
            end
         end
         ST_SIZE: begin
            if (accept) begin
               cmd.take_size = 1'b1;
               state_in      = status.size_zero ? ST_BCC : ST_DATA;
            end
         end
         ST_DATA: begin
            if (accept) begin
               cmd.take_data = 1'b1;
               if (status.data_done) begin
                  state_in = ST_BCC;
               end
            end
         end
         ST_BCC: begin
            if (accept) begin
               cmd.start_resp = 1'b1;
               state_in       = status.pkt_ok ? ST_RCMD : ST_ERR0;
            end
         end
         ST_ERR0: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = BEAT_ERR_MARK;
               cmd.err  = 1'b1;
               state_in = ST_ERR1;
            end
         end
         ST_ERR1: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = BEAT_ZERO;
               cmd.err  = 1'b1;
               state_in = ST_ERR2;
            end
         end
         ST_ERR2: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = BEAT_ERR_MARK;
               cmd.err  = 1'b1;
               cmd.last = 1'b1;
               state_in = ST_CMD;
            end
         end
         ST_RCMD: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = BEAT_CMD;
               state_in = ST_RSIZE;
            end
         end
         ST_RSIZE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = BEAT_SIZE;
               state_in = ST_RDATA;
            end
         end
         ST_RDATA: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.data_more) begin
                  cmd.sel = BEAT_DATA;
               end else begin
                  cmd.sel  = BEAT_BCC;
                  cmd.last = 1'b1;
                  state_in = ST_CMD;
               end
            end
         end
         default: begin
            state_in = ST_CMD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CMD;
      end else begin
         state_ff <= state_in;
      end
   end

   // a beat is loaded only when the response register can take it
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("response beat loaded into a full output register");

   // input and response bursts never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && cmd.emit))
      else $error("input taken while a response burst is running");

   // the final beat hands control back to the command phase
   a_last_returns: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |=> req_ready)
      else $error("no return to command phase after last beat");

endmodule

FILE: hdl/bpxr_dpath.sv
// ----------------------------------------------------------------------------
// bpxr_dpath
// Packet fields, running BCC, payload memory and response register.
// ----------------------------------------------------------------------------
module bpxr_dpath import bpxr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [BYTE_W-1:0] req_in_byte,
   input  logic              csr_valid,
   input  logic [BYTE_W-1:0] csr_xor_key,
   input  dp_cmd_type        cmd,
   output dp_status_type     status,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_last_byte,
   output logic              rsp_is_error
);

   logic [BYTE_W-1:0] key_ff;
   logic [BYTE_W-1:0] held_cmd_ff;
   logic [BYTE_W-1:0] held_size_ff;
   logic [BYTE_W-1:0] count_ff;
   logic [BYTE_W-1:0] bcc_ff;
   logic              oversize_ff;
   logic [PTR_W-1:0]  ptr_ff;
   logic [PTR_W-1:0]  ptr_in;
   logic [BYTE_W-1:0] resp_bcc_ff;
   logic [BYTE_W-1:0] rd_data_ff;
   logic [BYTE_W-1:0] payload_mem [MAX_PAYLOAD];

   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_last_ff;
   logic              rsp_error_ff;

   logic [BYTE_W-1:0] data_byte;
   logic [BYTE_W-1:0] beat_byte;
   logic              cmd_known;
   logic              store_en;

   assign data_byte = rd_data_ff ^ key_ff;
   assign cmd_known = (held_cmd_ff == CMD_ENC) || (held_cmd_ff == CMD_DEC);
   assign store_en  = cmd.take_data && (count_ff < BYTE_W'(MAX_PAYLOAD));

   assign status.size_zero = (req_in_byte == '0);
   assign status.data_done = ({1'b0, count_ff} + 9'd1) >= {1'b0, held_size_ff};
   assign status.pkt_ok    = (req_in_byte == bcc_ff) && !oversize_ff && cmd_known;
   assign status.data_more = (BYTE_W'(ptr_ff) < held_size_ff);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.start_resp) begin
         ptr_in = '0;
      end else if (cmd.emit && (cmd.sel == BEAT_DATA)) begin
         ptr_in = ptr_ff + PTR_W'(1);
      end
   end

   always_comb begin
      case (cmd.sel)
         BEAT_ERR_MARK: beat_byte = CMD_ERR;
         BEAT_ZERO:     beat_byte = '0;
         BEAT_CMD:      beat_byte = held_cmd_ff;
         BEAT_SIZE:     beat_byte = held_size_ff;
         BEAT_DATA:     beat_byte = data_byte;
         BEAT_BCC:      beat_byte = resp_bcc_ff;
         default:       beat_byte = '0;
      endcase
   end

   // control-side registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= KEY_RESET;
         held_cmd_ff  <= '0;
         held_size_ff <= '0;
         count_ff     <= '0;
         bcc_ff       <= '0;
         oversize_ff  <= 1'b0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            key_ff <= csr_xor_key;
         end
         if (cmd.take_cmd) begin
            held_cmd_ff <= req_in_byte;
            bcc_ff      <= req_in_byte;
         end
         if (cmd.take_size) begin
            held_size_ff <= req_in_byte;
            bcc_ff       <= bcc_ff ^ req_in_byte;
            count_ff     <= '0;
            oversize_ff  <= (req_in_byte > BYTE_W'(MAX_PAYLOAD));
         end
         if (cmd.take_data) begin
            bcc_ff   <= bcc_ff ^ req_in_byte;
            count_ff <= count_ff + BYTE_W'(1);
         end
         ptr_ff <= ptr_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response BCC and response output registers
   always_ff @(posedge clock) begin
      if (cmd.start_resp) begin
         resp_bcc_ff <= held_cmd_ff ^ held_size_ff;
      end else if (cmd.emit && (cmd.sel == BEAT_DATA)) begin
         resp_bcc_ff <= resp_bcc_ff ^ data_byte;
      end
      if (cmd.emit) begin
         rsp_byte_ff  <= beat_byte;
         rsp_last_ff  <= cmd.last;
         rsp_error_ff <= cmd.err;
      end
   end

   // payload memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (store_en) begin
         payload_mem[count_ff[IDX_W-1:0]] <= req_in_byte;
      end
      rd_data_ff <= payload_mem[ptr_in[IDX_W-1:0]];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_last_byte = rsp_last_ff;
   assign rsp_is_error  = rsp_error_ff;

endmodule

FILE: hdl/bcc_packet_xor_responder_top.sv
// ----------------------------------------------------------------------------
// bcc_packet_xor_responder_top
// Framed packet handler with XOR block check and keyed XOR response.
// ----------------------------------------------------------------------------
// Packets arrive one byte per req beat: command, size, size data bytes, then
// a BCC byte equal to the XOR of command, size and data. Up to 32 data bytes
// are kept in a payload memory with one write port and one registered read
// port. The BCC beat starts a response burst on the rsp channel, during
// which req_ready stays low: for commands 0x01 and 0x02 with a matching BCC
// and a size of at most 32 the burst is command, size, each data byte XORed
// with the key, and a fresh BCC over those bytes (size + 3 beats); anything
// else answers FF,00,FF with rsp_is_error set. rsp_last_byte marks the final
// beat. With rsp_ready held high one response beat leaves per cycle; the
// registered memory read port fetches the next entry as each data beat is
// loaded. A beat held in the output register stops the next one from being
// loaded until rsp_ready takes it. The key is written through the csr
// channel, which is always ready, and resets to 0xAA; write it only while no
// packet is in flight.
// ----------------------------------------------------------------------------
module bcc_packet_xor_responder_top import bpxr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // packet input
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_in_byte,
   // response output
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_last_byte,
   output logic              rsp_is_error,
   // key register write
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [BYTE_W-1:0] csr_xor_key
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // key writes never stall
   assign csr_ready = 1'b1;

   // framing and burst sequencing
   bpxr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // fields, check sum, payload memory and output register
   bpxr_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_in_byte   (req_in_byte),
      .csr_valid     (csr_valid),
      .csr_xor_key   (csr_xor_key),
      .cmd           (dp_cmd),
      .status        (dp_status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte),
      .rsp_is_error  (rsp_is_error)
   );

endmodule
